>>> rtl/space_vector_pwm_timing_assert.svh
// assertion macros of the svpwm timing rtl, included by svpt_back
// expects clk and rst_n in the scope of the including module
`ifndef SPACE_VECTOR_PWM_TIMING_ASSERT_SVH
`define SPACE_VECTOR_PWM_TIMING_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SVPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpt check failed");

// antecedent implies consequent in the next cycle
`define SVPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpt check failed");

`endif

>>> rtl/svpt_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants and types of the svpwm timing block
// no dependencies
package svpt_pkg;

    localparam int VOLT_W     = 16;
    localparam int BUS_W      = 15;
    localparam int TICK_W     = 16;
    localparam int PROD_W     = 34;
    localparam int REF_W      = 36;
    localparam int X_W        = 38;
    localparam int S_W        = 33;
    localparam int NUM_W      = 31;
    localparam int DIV_STEPS  = TICK_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [17:0] SQRT3_Q16 = 18'd113512;
    localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd1000;

    localparam logic [2:0] SECT_1 = 3'd0;
    localparam logic [2:0] SECT_2 = 3'd1;
    localparam logic [2:0] SECT_3 = 3'd2;
    localparam logic [2:0] SECT_4 = 3'd3;
    localparam logic [2:0] SECT_5 = 3'd4;
    localparam logic [2:0] SECT_6 = 3'd5;

    // classified vector, front to back
    typedef struct packed {
        logic [2:0][S_W-1:0] s;
        logic [BUS_W-1:0]    vbus;
        logic [2:0]          sector;
        logic                clip;
        logic                fault;
    } svpt_item_t;

    typedef struct packed {
        logic [2:0][TICK_W-1:0] on;
        logic [2:0]             sector;
        logic                   clip;
        logic                   fault;
    } svpt_res_t;

    typedef struct packed {
        logic [2:0][S_W-1:0]  plo;
        logic [2:0][31:0]     phi;
        logic [BUS_W-1:0]     vbus;
        logic [2:0]           sector;
        logic                 clip;
        logic                 fault;
    } svpt_mul_t;

    typedef struct packed {
        logic [2:0][BUS_W-1:0]  rem;
        logic [2:0][TICK_W-1:0] sh;
        logic [BUS_W-1:0]       vbus;
        logic [2:0]             sector;
        logic                   clip;
        logic                   fault;
    } svpt_div_t;

endpackage

>>> rtl/svpt_if.sv
`timescale 1ns / 1ps
// channel interfaces of the svpwm timing block: vector in, result out, period write
// depends on svpt_pkg
interface svpt_vec_if;
    logic                                valid;
    logic                                ready;
    logic signed [svpt_pkg::VOLT_W-1:0]  valpha;
    logic signed [svpt_pkg::VOLT_W-1:0]  vbeta;
    logic [svpt_pkg::BUS_W-1:0]          vbus;
    modport source (output valid, valpha, vbeta, vbus, input ready);
    modport sink (input valid, valpha, vbeta, vbus, output ready);
endinterface

interface svpt_res_if;
    logic                         valid;
    logic                         ready;
    logic [svpt_pkg::TICK_W-1:0]  on_time_a;
    logic [svpt_pkg::TICK_W-1:0]  on_time_b;
    logic [svpt_pkg::TICK_W-1:0]  on_time_c;
    logic [2:0]                   sector_index;
    logic                         clipped;
    logic                         bus_fault;
    modport source (output valid, on_time_a, on_time_b, on_time_c, sector_index, clipped,
                    bus_fault, input ready);
    modport sink (input valid, on_time_a, on_time_b, on_time_c, sector_index, clipped,
                  bus_fault, output ready);
endinterface

interface svpt_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [svpt_pkg::TICK_W-1:0]  period_ticks;
    modport source (output valid, period_ticks, input ready);
    modport sink (input valid, period_ticks, output ready);
endinterface

>>> rtl/svpt_front.sv
`timescale 1ns / 1ps
// front end: phase references, sector, min-max centring and clamp of each phase
// depends on svpt_pkg; pushes svpt_item_t beats into the queue
module svpt_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [svpt_pkg::VOLT_W-1:0] valpha,
    input  logic signed [svpt_pkg::VOLT_W-1:0] vbeta,
    input  logic [svpt_pkg::BUS_W-1:0]         vbus,
    input  logic                               full,
    output logic                               push,
    output svpt_pkg::svpt_item_t               item
);

    logic en;
    logic [2:0] v_reg;

    // stage 1
    logic signed [svpt_pkg::VOLT_W-1:0] va1_reg, vb1_reg;
    logic signed [svpt_pkg::PROD_W-1:0] ka1_reg, kb1_reg;
    logic [svpt_pkg::BUS_W-1:0]         bus1_reg;
    // stage 2
    logic signed [svpt_pkg::REF_W-1:0]  r2_reg [3];
    logic signed [svpt_pkg::REF_W-1:0]  r2_next [3];
    logic [2:0]                         sect2_reg, sect2_next;
    logic [svpt_pkg::BUS_W-1:0]         bus2_reg;
    // stage 3
    logic signed [svpt_pkg::REF_W-1:0]  r3_reg [3];
    logic signed [svpt_pkg::REF_W-1:0]  hi3_reg, lo3_reg, hi3_next, lo3_next;
    logic [2:0]                         sect3_reg;
    logic [svpt_pkg::BUS_W-1:0]         bus3_reg;

    assign en       = !v_reg[2] || !full;
    assign in_ready = en;
    assign push     = v_reg[2] && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // stage 2: references and sector from the registered products
    always_comb
    begin
        logic signed [svpt_pkg::REF_W-1:0]  va_q16;
        logic signed [svpt_pkg::PROD_W-1:0] b, ka;
        va_q16     = svpt_pkg::REF_W'(va1_reg) <<< 16;
        r2_next[0] = svpt_pkg::REF_W'(va1_reg) <<< 17;
        r2_next[1] = -va_q16 + svpt_pkg::REF_W'(kb1_reg);
        r2_next[2] = -va_q16 - svpt_pkg::REF_W'(kb1_reg);
        b  = svpt_pkg::PROD_W'(vb1_reg) <<< 16;
        ka = ka1_reg;
        if (!vb1_reg[svpt_pkg::VOLT_W-1])
        begin
            if (!va1_reg[svpt_pkg::VOLT_W-1])
                sect2_next = (b <= ka) ? svpt_pkg::SECT_1 : svpt_pkg::SECT_2;
            else
                sect2_next = (b > -ka) ? svpt_pkg::SECT_2 : svpt_pkg::SECT_3;
        end
        else
        begin
            if (va1_reg[svpt_pkg::VOLT_W-1])
                sect2_next = (b >= ka) ? svpt_pkg::SECT_4 : svpt_pkg::SECT_5;
            else
                sect2_next = (b < -ka) ? svpt_pkg::SECT_5 : svpt_pkg::SECT_6;
        end
    end

    // stage 3: largest and smallest reference
    always_comb
    begin
        hi3_next = r2_reg[0];
        lo3_next = r2_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (r2_reg[i] > hi3_next) hi3_next = r2_reg[i];
            if (r2_reg[i] < lo3_next) lo3_next = r2_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            va1_reg  <= valpha;
            vb1_reg  <= vbeta;
            ka1_reg  <= valpha * $signed(svpt_pkg::SQRT3_Q16);
            kb1_reg  <= vbeta * $signed(svpt_pkg::SQRT3_Q16);
            bus1_reg <= vbus;
            for (int i = 0; i < 3; i++)
            begin
                r2_reg[i] <= r2_next[i];
                r3_reg[i] <= r2_reg[i];
            end
            sect2_reg <= sect2_next;
            bus2_reg  <= bus1_reg;
            hi3_reg   <= hi3_next;
            lo3_reg   <= lo3_next;
            sect3_reg <= sect2_reg;
            bus3_reg  <= bus2_reg;
        end
    end

    // centring, offset by the bus and clamp to [0, 2*bus] in q17
    always_comb
    begin
        logic signed [svpt_pkg::X_W-1:0] x, s, den, half;
        logic any_clip;
        any_clip = 1'b0;
        half = $signed({6'b0, bus3_reg, 17'b0});
        den  = $signed({5'b0, bus3_reg, 18'b0});
        for (int i = 0; i < 3; i++)
        begin
            x = (svpt_pkg::X_W'(r3_reg[i]) <<< 1) - svpt_pkg::X_W'(hi3_reg)
                - svpt_pkg::X_W'(lo3_reg);
            s = x + half;
            if (s < 0)
            begin
                item.s[i] = '0;
                any_clip  = 1'b1;
            end
            else if (s > den)
            begin
                item.s[i] = den[svpt_pkg::S_W-1:0];
                any_clip  = 1'b1;
            end
            else
            begin
                item.s[i] = s[svpt_pkg::S_W-1:0];
            end
        end
        item.vbus   = bus3_reg;
        item.sector = sect3_reg;
        item.clip   = any_clip;
        item.fault  = (bus3_reg == '0);
    end

endmodule

>>> rtl/svpt_fifo.sv
`timescale 1ns / 1ps
// short queue between front and back, four entries
// depends on svpt_pkg
module svpt_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  svpt_pkg::svpt_item_t push_data,
    output logic                 full,
    input  logic                 pop,
    output svpt_pkg::svpt_item_t pop_data,
    output logic                 empty
);

    svpt_pkg::svpt_item_t mem [svpt_pkg::FIFO_DEPTH];
    logic [svpt_pkg::FIFO_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [svpt_pkg::FIFO_AW:0]   cnt_reg, cnt_next;

    assign full     = (cnt_reg == (svpt_pkg::FIFO_AW+1)'(svpt_pkg::FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/svpt_back.sv
`timescale 1ns / 1ps
// back end: period scaling and pipelined divide by the bus voltage, one step a stage
// depends on svpt_pkg and the assertion header
`include "space_vector_pwm_timing_assert.svh"
module svpt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [svpt_pkg::TICK_W-1:0] period,
    input  logic                        empty,
    input  svpt_pkg::svpt_item_t        fifo_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output svpt_pkg::svpt_res_t         out_data
);

    logic                             en;
    logic                             mul_v_reg;
    svpt_pkg::svpt_mul_t              mul_reg, mul_next;
    logic [svpt_pkg::DIV_STEPS:0]     v_reg;
    svpt_pkg::svpt_div_t              div_reg  [svpt_pkg::DIV_STEPS+1];
    svpt_pkg::svpt_div_t              div_next [svpt_pkg::DIV_STEPS+1];

    assign en        = !v_reg[svpt_pkg::DIV_STEPS] || out_ready;
    assign pop       = en && !empty;
    assign out_valid = v_reg[svpt_pkg::DIV_STEPS];

    // t * s split in two partial products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul_next.plo[i] = svpt_pkg::S_W'(period) * svpt_pkg::S_W'(fifo_data.s[i][16:0]);
            mul_next.phi[i] = 32'(period) * 32'(fifo_data.s[i][svpt_pkg::S_W-1:17]);
        end
        mul_next.vbus   = fifo_data.vbus;
        mul_next.sector = fifo_data.sector;
        mul_next.clip   = fifo_data.clip;
        mul_next.fault  = fifo_data.fault;
    end

    always_comb
    begin
        logic [49:0] n;
        logic [svpt_pkg::NUM_W-1:0] np;
        logic [svpt_pkg::BUS_W:0] r16;
        logic ge;
        // rounding half added, low 18 bits of the divisor dropped
        div_next[0] = div_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            n  = (50'(mul_reg.phi[i]) << 17) + 50'(mul_reg.plo[i]) + (50'(mul_reg.vbus) << 17);
            np = n[48:18];
            div_next[0].rem[i] = np[svpt_pkg::NUM_W-1:svpt_pkg::TICK_W];
            div_next[0].sh[i]  = np[svpt_pkg::TICK_W-1:0];
        end
        div_next[0].vbus   = mul_reg.vbus;
        div_next[0].sector = mul_reg.sector;
        div_next[0].clip   = mul_reg.clip;
        div_next[0].fault  = mul_reg.fault;
        for (int k = 1; k <= svpt_pkg::DIV_STEPS; k++)
        begin
            div_next[k] = div_reg[k-1];
            for (int i = 0; i < 3; i++)
            begin
                r16 = {div_reg[k-1].rem[i], div_reg[k-1].sh[i][svpt_pkg::TICK_W-1]};
                ge  = (r16 >= {1'b0, div_reg[k-1].vbus});
                div_next[k].rem[i] = ge ? svpt_pkg::BUS_W'(r16 - {1'b0, div_reg[k-1].vbus})
                                        : r16[svpt_pkg::BUS_W-1:0];
                div_next[k].sh[i]  = {div_reg[k-1].sh[i][svpt_pkg::TICK_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            v_reg     <= '0;
        end
        else if (en)
        begin
            mul_v_reg <= !empty;
            v_reg     <= {v_reg[svpt_pkg::DIV_STEPS-1:0], mul_v_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg <= mul_next;
            for (int k = 0; k <= svpt_pkg::DIV_STEPS; k++)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // zero bus forces zero on-times, sector and clip, and sets fault
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            out_data.on[i] = div_reg[svpt_pkg::DIV_STEPS].fault ? '0
                                                                : div_reg[svpt_pkg::DIV_STEPS].sh[i];
        end
        out_data.sector = div_reg[svpt_pkg::DIV_STEPS].fault ? svpt_pkg::SECT_1
                                                             : div_reg[svpt_pkg::DIV_STEPS].sector;
        out_data.clip   = div_reg[svpt_pkg::DIV_STEPS].clip && (period != '0) &&
                          !div_reg[svpt_pkg::DIV_STEPS].fault;
        out_data.fault  = div_reg[svpt_pkg::DIV_STEPS].fault;
    end

    `SVPT_ASSERT_IMP(a_fault_zero, out_valid && out_data.fault,
        out_data.on == '0 && !out_data.clip && out_data.sector == svpt_pkg::SECT_1)
    `SVPT_ASSERT_IMP(a_on_le_period, out_valid,
        out_data.on[0] <= period && out_data.on[1] <= period && out_data.on[2] <= period)
    `SVPT_ASSERT_NXT(a_pop_fills, pop, mul_v_reg)

endmodule

>>> rtl/space_vector_pwm_timing.sv
`timescale 1ns / 1ps
// throughput: one vector per cycle; the 16 stage restoring divider and a four entry
// queue between front and back set this, with the back stalling only on res.ready
// reset: asynchronous active low, empties all stages and the queue, period back to 1000
// depends on svpt_pkg, svpt_if, svpt_front, svpt_fifo, svpt_back
module space_vector_pwm_timing (
    input  logic        clk,
    input  logic        rst_n,
    svpt_vec_if.sink    vec,
    svpt_res_if.source  res,
    svpt_cfg_if.sink    cfg
);

    logic [svpt_pkg::TICK_W-1:0] period_reg, period_next;
    logic                        push, full, pop, empty;
    svpt_pkg::svpt_item_t        push_item, pop_item;
    svpt_pkg::svpt_res_t         out_data;

    assign cfg.ready   = 1'b1;
    assign period_next = (cfg.valid) ? cfg.period_ticks : period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= svpt_pkg::PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    svpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vec.valid),
        .in_ready (vec.ready),
        .valpha   (vec.valpha),
        .vbeta    (vec.vbeta),
        .vbus     (vec.vbus),
        .full     (full),
        .push     (push),
        .item     (push_item)
    );

    svpt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_item),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_item),
        .empty     (empty)
    );

    svpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .period    (period_reg),
        .empty     (empty),
        .fifo_data (pop_item),
        .pop       (pop),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (out_data)
    );

    assign res.on_time_a    = out_data.on[0];
    assign res.on_time_b    = out_data.on[1];
    assign res.on_time_c    = out_data.on[2];
    assign res.sector_index = out_data.sector;
    assign res.clipped      = out_data.clip;
    assign res.bus_fault    = out_data.fault;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for space_vector_pwm_timing: random and corner vectors, several periods
// depends on svpt_pkg, svpt_if and the rtl of space_vector_pwm_timing
module tb;

    typedef struct packed {
        logic signed [svpt_pkg::VOLT_W-1:0] valpha;
        logic signed [svpt_pkg::VOLT_W-1:0] vbeta;
        logic [svpt_pkg::BUS_W-1:0]         vbus;
    } vector_t;

    localparam longint Q16 = 65536;
    localparam longint ROOT3_Q16 = 113512;

    logic clk;
    logic rst_n;

    svpt_vec_if vec_if ();
    svpt_res_if res_if ();
    svpt_cfg_if cfg_if ();

    space_vector_pwm_timing dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_if.sink),
        .res   (res_if.source),
        .cfg   (cfg_if.sink)
    );

    vector_t              vectors_pending[$];
    svpt_pkg::svpt_res_t  timings_expected[$];
    logic [svpt_pkg::TICK_W-1:0] period_now;
    logic       no_idle;
    int         mismatches;
    logic       ended;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [2:0] sector_find(longint va, longint vb);
        longint b;
        longint ka;
        b = vb * Q16;
        ka = va * ROOT3_Q16;
        if (vb >= 0)
        begin
            if (va >= 0)
                return (b <= ka) ? svpt_pkg::SECT_1 : svpt_pkg::SECT_2;
            return (b > -ka) ? svpt_pkg::SECT_2 : svpt_pkg::SECT_3;
        end
        if (va < 0)
            return (b >= ka) ? svpt_pkg::SECT_4 : svpt_pkg::SECT_5;
        return (b < -ka) ? svpt_pkg::SECT_5 : svpt_pkg::SECT_6;
    endfunction

    function automatic svpt_pkg::svpt_res_t timing_predict(vector_t v,
                                                           logic [svpt_pkg::TICK_W-1:0] per);
        svpt_pkg::svpt_res_t r;
        longint va, vb, bus, t, hi, lo, x, num, den;
        longint ph[3];
        r = '0;
        if (v.vbus == 0)
        begin
            r.fault = 1'b1;
            return r;
        end
        va = longint'(v.valpha);
        vb = longint'(v.vbeta);
        bus = longint'(v.vbus);
        t = longint'(per);
        ph[0] = 2 * va * Q16;
        ph[1] = -va * Q16 + vb * ROOT3_Q16;
        ph[2] = -va * Q16 - vb * ROOT3_Q16;
        hi = ph[0];
        lo = ph[0];
        for (int i = 1; i < 3; i++)
        begin
            if (ph[i] > hi) hi = ph[i];
            if (ph[i] < lo) lo = ph[i];
        end
        den = bus * 4 * Q16;
        for (int i = 0; i < 3; i++)
        begin
            x = 2 * ph[i] - hi - lo;
            num = t * (bus * 2 * Q16 + x);
            if (num < 0)
            begin
                r.clip = 1'b1;
                r.on[i] = '0;
            end
            else if (num > t * den)
            begin
                r.clip = 1'b1;
                r.on[i] = per;
            end
            else
                r.on[i] = svpt_pkg::TICK_W'((num + den / 2) / den);
        end
        r.sector = sector_find(va, vb);
        return r;
    endfunction

    // source side: hold a beat until taken, predict at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_if.valid  <= 1'b0;
            vec_if.valpha <= '0;
            vec_if.vbeta  <= '0;
            vec_if.vbus   <= '0;
        end
        else
        begin
            if (vec_if.valid && vec_if.ready)
                timings_expected.push_back(timing_predict(
                    {vec_if.valpha, vec_if.vbeta, vec_if.vbus}, period_now));
            if (!vec_if.valid || vec_if.ready)
            begin
                if (vectors_pending.size() > 0 && (no_idle || $urandom_range(99) >= 13))
                begin
                    vector_t v;
                    v = vectors_pending.pop_front();
                    vec_if.valpha <= v.valpha;
                    vec_if.vbeta  <= v.vbeta;
                    vec_if.vbus   <= v.vbus;
                    vec_if.valid  <= 1'b1;
                end
                else
                    vec_if.valid <= 1'b0;
            end
        end
    end

    // sink side: random backpressure, compare each beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                svpt_pkg::svpt_res_t want;
                svpt_pkg::svpt_res_t got;
                got.on[0]  = res_if.on_time_a;
                got.on[1]  = res_if.on_time_b;
                got.on[2]  = res_if.on_time_c;
                got.sector = res_if.sector_index;
                got.clip   = res_if.clipped;
                got.fault  = res_if.bus_fault;
                if (timings_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: a=%0d b=%0d c=%0d", got.on[0],
                                 got.on[1], got.on[2]);
                end
                else
                begin
                    want = timings_expected.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp a=%0d b=%0d c=%0d s=%0d clip=%b flt=%b",
                                      " | got a=%0d b=%0d c=%0d s=%0d clip=%b flt=%b"},
                                     want.on[0], want.on[1], want.on[2], want.sector,
                                     want.clip, want.fault, got.on[0], got.on[1],
                                     got.on[2], got.sector, got.clip, got.fault);
                    end
                end
            end
            res_if.ready <= no_idle || ($urandom_range(99) >= 13);
        end
    end

    function automatic vector_t vector_random();
        vector_t v;
        int sel;
        int mag;
        sel = $urandom_range(99);
        v.valpha = svpt_pkg::VOLT_W'($urandom);
        v.vbeta  = svpt_pkg::VOLT_W'($urandom);
        v.vbus   = svpt_pkg::BUS_W'($urandom);
        if (sel < 60)
        begin
            // mostly inside the hexagon, some overmodulation
            v.vbus = svpt_pkg::BUS_W'($urandom_range(32767, 1));
            mag = (int'(v.vbus) * 2) / 3 + 1;
            v.valpha = svpt_pkg::VOLT_W'(int'($urandom_range(2 * mag, 0)) - mag);
            v.vbeta  = svpt_pkg::VOLT_W'(int'($urandom_range(2 * mag, 0)) - mag);
        end
        else if (sel < 75)
        begin
            v.vbus = svpt_pkg::BUS_W'($urandom_range(40, 1));
            v.valpha = svpt_pkg::VOLT_W'(int'($urandom_range(80, 0)) - 40);
            v.vbeta  = svpt_pkg::VOLT_W'(int'($urandom_range(80, 0)) - 40);
        end
        else if (sel < 80)
            v.vbus = '0;
        return v;
    endfunction

    task automatic corners_queue();
        vector_t d[$];
        d.push_back({16'sd0, 16'sd0, 15'd0});
        d.push_back({16'sd32767, 16'sd32767, 15'd32767});
        d.push_back({-16'sd32768, -16'sd32768, 15'd1});
        d.push_back({16'sd0, 16'sd0, 15'd100});
        d.push_back({16'sd500, 16'sd0, 15'd1000});
        d.push_back({-16'sd500, 16'sd0, 15'd1000});
        d.push_back({16'sd0, 16'sd500, 15'd1000});
        d.push_back({16'sd0, -16'sd500, 15'd1000});
        // beta exactly sqrt3 times alpha, all four diagonals
        d.push_back({16'sd8192, 16'sd14189, 15'd32767});
        d.push_back({-16'sd8192, 16'sd14189, 15'd32767});
        d.push_back({-16'sd8192, -16'sd14189, 15'd32767});
        d.push_back({16'sd8192, -16'sd14189, 15'd32767});
        d.push_back({16'sd32767, -16'sd32768, 15'd16384});
        d.push_back({-16'sd32768, 16'sd32767, 15'd16384});
        d.push_back({16'sd1, 16'sd1, 15'd1});
        d.push_back({-16'sd1, -16'sd1, 15'd32767});
        d.push_back({16'sd100, -16'sd40, 15'd300});
        d.push_back({-16'sd100, 16'sd40, 15'd0});
        d.push_back({16'sd20000, 16'sd0, 15'd30000});
        d.push_back({-16'sd20000, 16'sd0, 15'd30000});
        foreach (d[i])
            vectors_pending.push_back(d[i]);
    endtask

    task automatic drain_wait();
        while (vectors_pending.size() > 0 || vec_if.valid || timings_expected.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic period_write(logic [svpt_pkg::TICK_W-1:0] val);
        cfg_if.valid        <= 1'b1;
        cfg_if.period_ticks <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        period_now = val;
    endtask

    initial
    begin
        logic [svpt_pkg::TICK_W-1:0] periods[7];
        ended = 1'b0;
        mismatches = 0;
        no_idle = 1'b0;
        period_now = svpt_pkg::PERIOD_RESET;
        cfg_if.valid = 1'b0;
        cfg_if.period_ticks = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        periods = '{svpt_pkg::PERIOD_RESET, 16'd65535, 16'd1, 16'd0,
                    16'($urandom_range(65535, 2)), 16'd7, 16'd1000};
        foreach (periods[p])
        begin
            if (p > 0)
                period_write(periods[p]);
            no_idle = (p == 5);
            corners_queue();
            for (int i = 0; i < 250; i++)
                vectors_pending.push_back(vector_random());
            drain_wait();
        end
        ended = 1'b1;
        if (mismatches == 0)
            $display("** space_vector_pwm_timing: PASSED **");
        else
            $display("** space_vector_pwm_timing: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        if (!ended)
        begin
            $display("** space_vector_pwm_timing: FAILED **");
            $finish;
        end
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/svpt_pkg.sv
rtl/svpt_if.sv
rtl/svpt_front.sv
rtl/svpt_fifo.sv
rtl/svpt_back.sv
rtl/space_vector_pwm_timing.sv
bench/tb.sv
